/* hw/rtl/crta_pkg.sv */
// Shared types and constants of the CAN response time analyzer.
`default_nettype none
package crta_pkg;

    localparam int PRIO_W  = 11;
    localparam int JIT_W   = 24;
    localparam int IDX_W   = 6;
    localparam int RESP_W  = 25;
    localparam int TOTAL_W = 31;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    typedef enum logic [0:0] {
        CMD_LOAD  = 1'b0,
        CMD_START = 1'b1
    } req_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_I,
        ST_LATCH_I,
        ST_BLK_RD,
        ST_BLK_CHK,
        ST_BLK_END,
        ST_IT_RD,
        ST_IT_CHK,
        ST_DIV,
        ST_MUL_INIT,
        ST_MUL,
        ST_ACC,
        ST_IT_END,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load_we;
        logic run_init;
        logic rd_k;
        logic ent_latch;
        logic blk_step;
        logic k_clr;
        logic k_inc;
        logic iter_init;
        logic div_start;
        logic div_step;
        logic mul_start;
        logic mul_step;
        logic acc;
        logic q_update;
        logic set_fail;
        logic set_done;
        logic emit;
        logic i_inc;
    } ctrl_cmd_t;

    typedef struct packed {
        logic empty;
        logic k_last;
        logic i_last;
        logic rd_period_zero;
        logic rd_higher;
        logic blk_gt_ti;
        logic step_last;
        logic prod_gt_ti;
        logic t_over;
        logic fixed;
        logic out_free;
    } ctrl_sts_t;

endpackage
`default_nettype wire

/* hw/rtl/crta_req_if.sv */
// Request channel: load or start command with one message entry.
`default_nettype none
interface crta_req_if #(
    parameter int TIME_WIDTH = 24
);
    import crta_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  cmd;
    logic [PRIO_W-1:0]     priority_req;
    logic [TIME_WIDTH-1:0] tx_time;
    logic [TIME_WIDTH-1:0] period;

    modport source (output valid, cmd, priority_req, tx_time, period, input ready);
    modport sink   (input valid, cmd, priority_req, tx_time, period, output ready);
endinterface
`default_nettype wire

/* hw/rtl/crta_rsp_if.sv */
// Result channel: per-entry response time and run summary.
`default_nettype none
interface crta_rsp_if;
    import crta_pkg::*;

    logic               valid;
    logic               ready;
    logic [IDX_W-1:0]   msg_index;
    logic [RESP_W-1:0]  response_time;
    logic               schedulable;
    logic [TOTAL_W-1:0] total_time;
    logic               all_schedulable;
    logic               last;

    modport source (output valid, msg_index, response_time, schedulable, total_time,
                    all_schedulable, last, input ready);
    modport sink   (input valid, msg_index, response_time, schedulable, total_time,
                    all_schedulable, last, output ready);
endinterface
`default_nettype wire

/* hw/rtl/crta_ctrl.sv */
// Sequencer of the response time analysis.
`default_nettype none
module crta_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_cmd,
    output logic                    in_ready,
    input  wire crta_pkg::ctrl_sts_t sts,
    output crta_pkg::ctrl_cmd_t     cmd
);
    import crta_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_cmd == CMD_START)
                    begin
                        if (!sts.empty)
                        begin
                            cmd.run_init = 1'b1;
                            state_next   = ST_RD_I;
                        end
                    end
                    else
                    begin
                        cmd.load_we = 1'b1;
                    end
                end
            end
            ST_RD_I:
            begin
                state_next = ST_LATCH_I;
            end
            ST_LATCH_I:
            begin
                cmd.ent_latch = 1'b1;
                cmd.k_clr     = 1'b1;
                if (sts.rd_period_zero)
                begin
                    cmd.set_fail = 1'b1;
                    state_next   = ST_EMIT;
                end
                else
                begin
                    state_next = ST_BLK_RD;
                end
            end
            ST_BLK_RD:
            begin
                cmd.rd_k   = 1'b1;
                state_next = ST_BLK_CHK;
            end
            ST_BLK_CHK:
            begin
                cmd.blk_step = 1'b1;
                if (sts.k_last)
                begin
                    state_next = ST_BLK_END;
                end
                else
                begin
                    cmd.k_inc  = 1'b1;
                    state_next = ST_BLK_RD;
                end
            end
            ST_BLK_END:
            begin
                if (sts.blk_gt_ti)
                begin
                    cmd.set_fail = 1'b1;
                    state_next   = ST_EMIT;
                end
                else
                begin
                    cmd.iter_init = 1'b1;
                    cmd.k_clr     = 1'b1;
                    state_next    = ST_IT_RD;
                end
            end
            ST_IT_RD:
            begin
                cmd.rd_k   = 1'b1;
                state_next = ST_IT_CHK;
            end
            ST_IT_CHK:
            begin
                if (!sts.rd_higher)
                begin
                    if (sts.k_last)
                    begin
                        state_next = ST_IT_END;
                    end
                    else
                    begin
                        cmd.k_inc  = 1'b1;
                        state_next = ST_IT_RD;
                    end
                end
                else if (sts.rd_period_zero)
                begin
                    cmd.set_fail = 1'b1;
                    state_next   = ST_EMIT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.step_last)
                begin
                    state_next = ST_MUL_INIT;
                end
            end
            ST_MUL_INIT:
            begin
                cmd.mul_start = 1'b1;
                state_next    = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (sts.step_last)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                if (sts.prod_gt_ti || sts.t_over)
                begin
                    cmd.set_fail = 1'b1;
                    state_next   = ST_EMIT;
                end
                else
                begin
                    cmd.acc = 1'b1;
                    if (sts.k_last)
                    begin
                        state_next = ST_IT_END;
                    end
                    else
                    begin
                        cmd.k_inc  = 1'b1;
                        state_next = ST_IT_RD;
                    end
                end
            end
            ST_IT_END:
            begin
                if (sts.fixed)
                begin
                    cmd.set_done = 1'b1;
                    state_next   = ST_EMIT;
                end
                else
                begin
                    cmd.q_update = 1'b1;
                    cmd.k_clr    = 1'b1;
                    state_next   = ST_IT_RD;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.i_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.i_inc  = 1'b1;
                        state_next = ST_RD_I;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

/* hw/rtl/crta_dp.sv */
// Datapath: message table, blocking search, ceiling divider, multiplier, totals.
`default_nettype none
module crta_dp #(
    parameter int MAX_MSGS   = 64,
    parameter int TIME_WIDTH = 24
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire crta_pkg::ctrl_cmd_t            cmd,
    output crta_pkg::ctrl_sts_t                 sts,
    input  wire logic [crta_pkg::PRIO_W-1:0]    ld_prio,
    input  wire logic [TIME_WIDTH-1:0]          ld_tx,
    input  wire logic [TIME_WIDTH-1:0]          ld_period,
    input  wire logic                           jit_we,
    input  wire logic [crta_pkg::JIT_W-1:0]     jit_data,
    input  wire logic                           out_ready,
    output logic                                out_valid,
    output logic [crta_pkg::IDX_W-1:0]          out_index,
    output logic [crta_pkg::RESP_W-1:0]         out_resp,
    output logic                                out_ok,
    output logic [crta_pkg::TOTAL_W-1:0]        out_total,
    output logic                                out_all_ok,
    output logic                                out_last
);
    import crta_pkg::*;

    localparam int T   = TIME_WIDTH;
    localparam int AW  = $clog2(MAX_MSGS);
    localparam int CW  = $clog2(MAX_MSGS + 1);
    localparam int EW  = PRIO_W + 2 * T;
    localparam int QW  = ((T > JIT_W) ? T : JIT_W) + 1;
    localparam int SCW = $clog2(QW);
    localparam int PW  = QW + T;
    localparam int RSW = ((T + 1) > RESP_W) ? (T + 1) : RESP_W;
    localparam int SW  = ((RSW > TOTAL_W) ? RSW : TOTAL_W) + 1;

    logic [EW-1:0]      mem [MAX_MSGS];
    logic [EW-1:0]      rd_data_reg;
    logic [CW-1:0]      count_reg;
    logic [JIT_W-1:0]   jit_reg;
    logic [AW-1:0]      i_reg;
    logic [AW-1:0]      k_reg;
    logic [PRIO_W-1:0]  pi_reg;
    logic [T-1:0]       ti_reg;
    logic [T-1:0]       txi_reg;
    logic [T-1:0]       blk_reg;
    logic [T-1:0]       q_reg;
    logic [T-1:0]       t_reg;
    logic [T-1:0]       dvs_reg;
    logic [T-1:0]       txk_reg;
    logic [QW-1:0]      sh_reg;
    logic [T-1:0]       rem_reg;
    logic [PW-1:0]      prod_reg;
    logic [SCW-1:0]     cnt_reg;
    logic [RSW-1:0]     resp_reg;
    logic               ok_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic               all_ok_reg;
    logic               out_valid_reg;
    logic [IDX_W-1:0]   out_index_reg;
    logic [RESP_W-1:0]  out_resp_reg;
    logic               out_ok_reg;
    logic [TOTAL_W-1:0] out_total_reg;
    logic               out_all_ok_reg;
    logic               out_last_reg;

    logic               full;
    logic [AW-1:0]      rd_addr;
    logic [PRIO_W-1:0]  rd_prio;
    logic [T-1:0]       rd_tx;
    logic [T-1:0]       rd_per;
    logic [T:0]         rem_sh;
    logic               rem_ge;
    logic [T:0]         rem_sub;
    logic [QW-1:0]      nk;
    logic [PW-1:0]      prod_next;
    logic [T:0]         t_sum;
    logic [SW-1:0]      total_sum;
    logic [TOTAL_W-1:0] total_next;
    logic               all_ok_next;

    assign full    = (count_reg == CW'(MAX_MSGS));
    assign rd_addr = cmd.rd_k ? k_reg : i_reg;
    assign rd_prio = rd_data_reg[EW-1 -: PRIO_W];
    assign rd_tx   = rd_data_reg[2*T-1 -: T];
    assign rd_per  = rd_data_reg[T-1:0];

    assign rem_sh    = {rem_reg, sh_reg[QW-1]};
    assign rem_ge    = (rem_sh >= {1'b0, dvs_reg});
    assign rem_sub   = rem_sh - {1'b0, dvs_reg};
    assign nk        = sh_reg + QW'(rem_reg != '0);
    assign prod_next = {prod_reg[PW-2:0], 1'b0} + (sh_reg[QW-1] ? PW'(txk_reg) : '0);
    assign t_sum     = {1'b0, t_reg} + {1'b0, prod_reg[T-1:0]};

    assign total_sum   = SW'(total_reg) + SW'(resp_reg);
    assign total_next  = (total_sum > SW'(TOTAL_MAX)) ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
    assign all_ok_next = all_ok_reg & ok_reg;

    assign sts.empty          = (count_reg == '0);
    assign sts.k_last         = ((CW'(k_reg) + CW'(1)) == count_reg);
    assign sts.i_last         = ((CW'(i_reg) + CW'(1)) == count_reg);
    assign sts.rd_period_zero = (rd_per == '0);
    assign sts.rd_higher      = (rd_prio < pi_reg);
    assign sts.blk_gt_ti      = (blk_reg > ti_reg);
    assign sts.step_last      = (cnt_reg == SCW'(QW - 1));
    assign sts.prod_gt_ti     = (prod_reg > PW'(ti_reg));
    assign sts.t_over         = (t_sum > {1'b0, ti_reg});
    assign sts.fixed          = (t_reg == q_reg);
    assign sts.out_free       = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.load_we && !full)
        begin
            mem[count_reg[AW-1:0]] <= {ld_prio, ld_tx, ld_period};
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            jit_reg        <= '0;
            i_reg          <= '0;
            k_reg          <= '0;
            pi_reg         <= '0;
            ti_reg         <= '0;
            txi_reg        <= '0;
            blk_reg        <= '0;
            q_reg          <= '0;
            t_reg          <= '0;
            dvs_reg        <= '0;
            txk_reg        <= '0;
            sh_reg         <= '0;
            rem_reg        <= '0;
            prod_reg       <= '0;
            cnt_reg        <= '0;
            resp_reg       <= '0;
            ok_reg         <= 1'b0;
            total_reg      <= '0;
            all_ok_reg     <= 1'b1;
            out_valid_reg  <= 1'b0;
            out_index_reg  <= '0;
            out_resp_reg   <= '0;
            out_ok_reg     <= 1'b0;
            out_total_reg  <= '0;
            out_all_ok_reg <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (jit_we)
            begin
                jit_reg <= jit_data;
            end
            if (cmd.load_we && !full)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.run_init)
            begin
                i_reg      <= '0;
                total_reg  <= '0;
                all_ok_reg <= 1'b1;
            end
            if (cmd.i_inc)
            begin
                i_reg <= i_reg + AW'(1);
            end
            if (cmd.k_clr)
            begin
                k_reg <= '0;
            end
            if (cmd.k_inc)
            begin
                k_reg <= k_reg + AW'(1);
            end
            if (cmd.ent_latch)
            begin
                pi_reg  <= rd_prio;
                ti_reg  <= rd_per;
                txi_reg <= rd_tx;
                blk_reg <= '0;
            end
            if (cmd.blk_step && (rd_prio >= pi_reg) && (rd_tx > blk_reg))
            begin
                blk_reg <= rd_tx;
            end
            if (cmd.iter_init)
            begin
                q_reg <= blk_reg;
                t_reg <= blk_reg;
            end
            if (cmd.q_update)
            begin
                q_reg <= t_reg;
                t_reg <= blk_reg;
            end
            if (cmd.acc)
            begin
                t_reg <= t_sum[T-1:0];
            end
            if (cmd.div_start)
            begin
                dvs_reg <= rd_per;
                txk_reg <= rd_tx;
                sh_reg  <= QW'(q_reg) + QW'(jit_reg);
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            if (cmd.div_step)
            begin
                rem_reg <= rem_ge ? rem_sub[T-1:0] : rem_sh[T-1:0];
                sh_reg  <= {sh_reg[QW-2:0], rem_ge};
                cnt_reg <= cnt_reg + SCW'(1);
            end
            if (cmd.mul_start)
            begin
                sh_reg   <= nk;
                prod_reg <= '0;
                cnt_reg  <= '0;
            end
            if (cmd.mul_step)
            begin
                prod_reg <= prod_next;
                sh_reg   <= {sh_reg[QW-2:0], 1'b0};
                cnt_reg  <= cnt_reg + SCW'(1);
            end
            if (cmd.set_fail)
            begin
                ok_reg   <= 1'b0;
                resp_reg <= '0;
            end
            if (cmd.set_done)
            begin
                ok_reg   <= 1'b1;
                resp_reg <= RSW'(q_reg) + RSW'(txi_reg);
            end
            if (cmd.emit)
            begin
                total_reg      <= total_next;
                all_ok_reg     <= all_ok_next;
                out_valid_reg  <= 1'b1;
                out_index_reg  <= IDX_W'(i_reg);
                out_resp_reg   <= resp_reg[RESP_W-1:0];
                out_ok_reg     <= ok_reg;
                out_total_reg  <= sts.i_last ? total_next : '0;
                out_all_ok_reg <= sts.i_last && all_ok_next;
                out_last_reg   <= sts.i_last;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_index  = out_index_reg;
    assign out_resp   = out_resp_reg;
    assign out_ok     = out_ok_reg;
    assign out_total  = out_total_reg;
    assign out_all_ok = out_all_ok_reg;
    assign out_last   = out_last_reg;
endmodule
`default_nettype wire

/* hw/rtl/can_response_time_analyzer.sv */
// Top level of the CAN worst-case response time analyzer.
//
//  channel      dir  handshake      contents
//  req          in   valid/ready    cmd, priority_req, tx_time, period
//  rsp          out  valid/ready    msg_index, response_time, schedulable, totals, last
//  bus_jitter   in   write enable   bus_jitter_data
//
// A load request appends one entry while the table is not full. A start runs every loaded
// entry in turn: a blocking search over all N entries, then fixed-point passes, each reading
// the N entries in turn and, for each higher-priority entry, running a ceiling division and
// a multiplication of Q = max(TIME_WIDTH, 24) + 1 bits on the shared serial divider and
// multiplier; the table has one read port, so entries are read one at a time.
// Reset clears the entry count, jitter and run state; the table itself is not cleared.
// A stalled result holds the run at its next result; requests wait until the run ends.
`default_nettype none
module can_response_time_analyzer #(
    parameter int MAX_MSGS   = 64,
    parameter int TIME_WIDTH = 24
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    crta_req_if.sink                        req,
    crta_rsp_if.source                      rsp,
    input  wire logic                       bus_jitter_we,
    input  wire logic [crta_pkg::JIT_W-1:0] bus_jitter_data
);
    import crta_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    crta_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_cmd   (req.cmd),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    crta_dp #(
        .MAX_MSGS   (MAX_MSGS),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .ld_prio    (req.priority_req),
        .ld_tx      (req.tx_time),
        .ld_period  (req.period),
        .jit_we     (bus_jitter_we),
        .jit_data   (bus_jitter_data),
        .out_ready  (rsp.ready),
        .out_valid  (rsp.valid),
        .out_index  (rsp.msg_index),
        .out_resp   (rsp.response_time),
        .out_ok     (rsp.schedulable),
        .out_total  (rsp.total_time),
        .out_all_ok (rsp.all_schedulable),
        .out_last   (rsp.last)
    );

    a_summary_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.last) |-> (rsp.total_time == '0 && !rsp.all_schedulable))
        else $error("summary fields set on a result that is not last");

    a_fail_zero_time: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.schedulable) |-> (rsp.response_time == '0))
        else $error("unschedulable entry carries a response time");

    a_all_ok_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.all_schedulable) |-> (rsp.schedulable && rsp.last))
        else $error("all_schedulable set with a failing or non-final result");

    a_busy_blocks_req: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && !sts.i_last) |=> !req.ready)
        else $error("request taken in the middle of a run");
endmodule
`default_nettype wire
